// ----- hw/rtl/interval_set_insert_coalesce_defines.svh -----
// Assertion macros for the coalesced interval table.
`ifndef INTERVAL_SET_INSERT_COALESCE_DEFINES_SVH
`define INTERVAL_SET_INSERT_COALESCE_DEFINES_SVH

// Check that a condition holds in the same cycle as its trigger.
`define ISC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check that a condition holds in the cycle after its trigger.
`define ISC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/isc_pkg.sv -----
// Shared constants, codes and types for the coalesced interval table.
`timescale 1ns / 1ps

package isc_pkg;

  localparam int CAPACITY  = 32;
  localparam int TIME_BITS = 32;
  localparam int ADDR_W    = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int ACT_W     = 2;
  localparam int STAT_W    = 2;
  localparam int ENTRY_W   = 2 * TIME_BITS;

  typedef logic signed [TIME_BITS-1:0] time_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_READ   = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_REVERSED = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_SHUP,
    ST_SHDN,
    ST_RDWAIT,
    ST_DONE
  } state_t;

endpackage

// ----- hw/rtl/interval_set_insert_coalesce.sv -----
// Top level of the coalesced interval table: sequencer, entry memory and result register.
`timescale 1ns / 1ps
`include "interval_set_insert_coalesce_defines.svh"

// Keeps up to CAPACITY disjoint closed windows [start, stop], sorted by start, in one
// memory of {start, stop} words with one read and one write port and a registered read.
// One item is worked at a time. An insert scans the stored windows one per cycle until it
// passes the new window, then either opens a gap (moving the upper entries up one per
// cycle) or writes the merged window and closes the hole (moving the upper entries down
// one per cycle); an insert that needs a fresh slot on a full table is dropped.
// The next item is taken while the previous result still waits on a stalled output.
// No clearing pass after reset.
module interval_set_insert_coalesce (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [isc_pkg::ACT_W-1:0]    in_action,
  input  isc_pkg::time_t               in_win_start,
  input  isc_pkg::time_t               in_win_stop,
  input  logic [isc_pkg::ADDR_W-1:0]   in_entry_index,
  output logic                         out_valid,
  input  logic                         out_stall,
  output isc_pkg::time_t               out_entry_start,
  output isc_pkg::time_t               out_entry_stop,
  output logic                         out_read_valid,
  output logic [isc_pkg::CNT_W-1:0]    out_entry_count,
  output logic [isc_pkg::STAT_W-1:0]   out_status
);
  import isc_pkg::*;

  // Control state
  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     count_r;
  logic                 out_valid_r;

  // Item registers
  time_t                s_r, e_r, ns_r, ne_r;
  logic [ADDR_W-1:0]    idx_r;
  logic                 found_r;
  logic [CNT_W-1:0]     lo_r, hi_r;
  logic [CNT_W-1:0]     scan_ptr_r, cmp_addr_r;
  logic                 cmp_vld_r;
  logic [CNT_W-1:0]     cnt_r, removed_r;
  logic [ADDR_W-1:0]    rd_ptr_r, wb_addr_r;
  logic                 wb_vld_r;

  // Result registers
  time_t                res_start_r, res_stop_r;
  logic                 res_rv_r;
  status_t              res_status_r;
  time_t                out_start_r, out_stop_r;
  logic                 out_rv_r;
  logic [CNT_W-1:0]     out_count_r;
  status_t              out_status_r;

  // Memory
  logic [ENTRY_W-1:0]   mem [CAPACITY];
  logic [ENTRY_W-1:0]   rdata_r;
  logic [ADDR_W-1:0]    mem_ra;
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_wa;
  logic [ENTRY_W-1:0]   mem_wd;

  // Handshake and scan decode
  logic                 in_xfer, out_free, load_out;
  action_t              act;
  time_t                d_start, d_stop;
  logic                 stop_ge, start_le, hit_end, scan_fin, move_done;

  assign act      = action_t'(in_action);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign d_start  = rdata_r[ENTRY_W-1:TIME_BITS];
  assign d_stop   = rdata_r[TIME_BITS-1:0];
  assign stop_ge  = d_stop >= s_r;
  assign start_le = d_start <= e_r;
  assign hit_end  = cmp_vld_r && (found_r || stop_ge) && !start_le;
  assign scan_fin = hit_end || (scan_ptr_r >= count_r);
  assign move_done = (cnt_r == '0) && !wb_vld_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (act)
            ACT_INSERT: state_nxt = (in_win_start > in_win_stop) ? ST_DONE : ST_SCAN;
            ACT_READ:   state_nxt = ST_RDWAIT;
            default:    state_nxt = ST_DONE;
          endcase
        end
      end
      ST_SCAN:   if (scan_fin) state_nxt = ST_DECIDE;
      ST_DECIDE: begin
        if (lo_r != hi_r) begin
          state_nxt = ST_SHDN;
        end else if (count_r >= CNT_W'(CAPACITY)) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_SHUP;
        end
      end
      ST_SHUP:   if (move_done) state_nxt = ST_DONE;
      ST_SHDN:   if (move_done) state_nxt = ST_DONE;
      ST_RDWAIT: state_nxt = ST_DONE;
      ST_DONE:   if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: handshake and memory port controls
  always_comb begin
    in_stall = (state_r != ST_IDLE);
    load_out = (state_r == ST_DONE) && out_free;
    mem_ra   = '0;
    mem_we   = 1'b0;
    mem_wa   = '0;
    mem_wd   = rdata_r;
    unique case (state_r)
      ST_IDLE:   mem_ra = in_entry_index;
      ST_SCAN:   mem_ra = scan_ptr_r[ADDR_W-1:0];
      ST_DECIDE: begin
        // write the merged window over the first overlapped entry
        if (lo_r != hi_r) begin
          mem_we = 1'b1;
          mem_wa = lo_r[ADDR_W-1:0];
          mem_wd = {ns_r, ne_r};
        end
      end
      ST_SHUP: begin
        mem_ra = rd_ptr_r;
        if (wb_vld_r) begin
          mem_we = 1'b1;
          mem_wa = wb_addr_r;
        end else if (cnt_r == '0) begin
          // gap is open: place the new window
          mem_we = 1'b1;
          mem_wa = lo_r[ADDR_W-1:0];
          mem_wd = {s_r, e_r};
        end
      end
      ST_SHDN: begin
        mem_ra = rd_ptr_r;
        if (wb_vld_r) begin
          mem_we = 1'b1;
          mem_wa = wb_addr_r;
        end
      end
      default: ;
    endcase
  end

  // Entry memory: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_r <= mem[mem_ra];
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Count and item datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      cmp_vld_r <= 1'b0;
      wb_vld_r  <= 1'b0;
      found_r   <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            res_start_r  <= '0;
            res_stop_r   <= '0;
            res_rv_r     <= 1'b0;
            res_status_r <= STAT_OK;
            s_r          <= in_win_start;
            e_r          <= in_win_stop;
            ns_r         <= in_win_start;
            ne_r         <= in_win_stop;
            idx_r        <= in_entry_index;
            found_r      <= 1'b0;
            lo_r         <= '0;
            hi_r         <= '0;
            scan_ptr_r   <= '0;
            cmp_vld_r    <= 1'b0;
            wb_vld_r     <= 1'b0;
            unique case (act)
              ACT_INSERT: begin
                if (in_win_start > in_win_stop) res_status_r <= STAT_REVERSED;
              end
              ACT_CLEAR: count_r <= '0;
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          // issue the next read while judging the previous one
          cmp_vld_r  <= (scan_ptr_r < count_r);
          cmp_addr_r <= scan_ptr_r;
          if (scan_ptr_r < count_r) scan_ptr_r <= scan_ptr_r + 1'b1;
          if (cmp_vld_r) begin
            if (!found_r) begin
              if (!stop_ge) begin
                lo_r <= cmp_addr_r + 1'b1;
                hi_r <= cmp_addr_r + 1'b1;
              end else begin
                found_r <= 1'b1;
                lo_r    <= cmp_addr_r;
                hi_r    <= start_le ? cmp_addr_r + 1'b1 : cmp_addr_r;
                ns_r    <= (d_start < s_r) ? d_start : s_r;
                if (start_le) ne_r <= (d_stop > e_r) ? d_stop : e_r;
              end
            end else if (start_le) begin
              hi_r <= cmp_addr_r + 1'b1;
              ne_r <= (d_stop > e_r) ? d_stop : e_r;
            end
          end
        end
        ST_DECIDE: begin
          wb_vld_r <= 1'b0;
          if (lo_r != hi_r) begin
            // merge: drop the extra overlapped entries and close the hole
            removed_r <= hi_r - lo_r - 1'b1;
            count_r   <= count_r - (hi_r - lo_r - 1'b1);
            cnt_r     <= count_r - hi_r;
            rd_ptr_r  <= hi_r[ADDR_W-1:0];
          end else if (count_r >= CNT_W'(CAPACITY)) begin
            res_status_r <= STAT_FULL;
          end else begin
            // open a gap at lo, moving from the top down
            cnt_r    <= count_r - lo_r;
            rd_ptr_r <= count_r[ADDR_W-1:0] - 1'b1;
          end
        end
        ST_SHUP: begin
          if (cnt_r != '0) begin
            wb_vld_r  <= 1'b1;
            wb_addr_r <= rd_ptr_r + 1'b1;
            rd_ptr_r  <= rd_ptr_r - 1'b1;
            cnt_r     <= cnt_r - 1'b1;
          end else begin
            wb_vld_r <= 1'b0;
            if (!wb_vld_r) count_r <= count_r + 1'b1;
          end
        end
        ST_SHDN: begin
          if (cnt_r != '0) begin
            wb_vld_r  <= 1'b1;
            wb_addr_r <= rd_ptr_r - removed_r[ADDR_W-1:0];
            rd_ptr_r  <= rd_ptr_r + 1'b1;
            cnt_r     <= cnt_r - 1'b1;
          end else begin
            wb_vld_r <= 1'b0;
          end
        end
        ST_RDWAIT: begin
          // gate the read by the count
          if (CNT_W'(idx_r) < count_r) begin
            res_start_r <= d_start;
            res_stop_r  <= d_stop;
            res_rv_r    <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Result register: hold until the transfer completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_start_r  <= res_start_r;
      out_stop_r   <= res_stop_r;
      out_rv_r     <= res_rv_r;
      out_count_r  <= count_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_entry_start = out_start_r;
  assign out_entry_stop  = out_stop_r;
  assign out_read_valid  = out_rv_r;
  assign out_entry_count = out_count_r;
  assign out_status      = out_status_r;

  // Checks
  `ISC_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNT_W'(CAPACITY), "count above capacity")
  `ISC_ASSERT_NOW(a_scan_no_write, state_r == ST_SCAN, !mem_we, "memory written during scan")
  `ISC_ASSERT_NOW(a_full_count, out_valid_r && (out_status_r == STAT_FULL), out_count_r == CNT_W'(CAPACITY), "full status below capacity")
  `ISC_ASSERT_NEXT(a_shup_grow, (state_r == ST_SHUP) && move_done, count_r == $past(count_r) + 1'b1, "insert did not grow count")

endmodule

// ----- bench/testbench.sv -----
// Self-checking testbench for the coalesced interval table: stimulus, prediction, checking.
`timescale 1ns / 1ps

module testbench;
  import isc_pkg::*;

  localparam int    PHASES         = 4;
  localparam int    PHASE_ITEMS    = 275;
  localparam int    SETTLE_CYCLES  = 60;
  localparam int    WATCHDOG_LIMIT = 4000;
  localparam int    MAX_PRINTED    = 40;
  localparam time_t T_MIN          = {1'b1, {(TIME_BITS-1){1'b0}}};
  localparam time_t T_MAX          = {1'b0, {(TIME_BITS-1){1'b1}}};

  // Shadow copy of the window table; predicts and checks every transfer.
  class coalesce_scoreboard;
    typedef struct {
      time_t              lo;
      time_t              hi;
      logic               rd_ok;
      logic [CNT_W-1:0]   count;
      status_t            stat;
    } answer_t;

    time_t       win_lo[CAPACITY];
    time_t       win_hi[CAPACITY];
    int          stored;
    answer_t     answers[$];
    int unsigned errors;
    int unsigned n_insert, n_merge, n_full, n_reversed;
    int unsigned n_read_hit, n_read_miss, n_clear;
    int          peak;

    // Place a well-ordered window, merging every stored window it overlaps or touches.
    function void place_window(time_t s, time_t e, output status_t st);
      int lo_i;
      int hi_i;
      int gap;
      int i;
      st = STAT_OK;
      lo_i = 0;
      while (lo_i < stored && win_hi[lo_i] < s) lo_i++;
      hi_i = lo_i;
      while (hi_i < stored && win_lo[hi_i] <= e) hi_i++;
      if (hi_i == lo_i) begin
        // no overlap: needs a fresh slot
        if (stored >= CAPACITY) begin
          st = STAT_FULL;
          n_full++;
          return;
        end
        for (i = stored; i > lo_i; i--) begin
          win_lo[i] = win_lo[i-1];
          win_hi[i] = win_hi[i-1];
        end
        win_lo[lo_i] = s;
        win_hi[lo_i] = e;
        stored++;
      end else begin
        // widen the first hit and close the hole left by the absorbed ones
        if (win_lo[lo_i] < s) s = win_lo[lo_i];
        if (win_hi[hi_i-1] > e) e = win_hi[hi_i-1];
        gap = hi_i - lo_i - 1;
        win_lo[lo_i] = s;
        win_hi[lo_i] = e;
        for (i = hi_i; i < stored; i++) begin
          win_lo[i-gap] = win_lo[i];
          win_hi[i-gap] = win_hi[i];
        end
        stored -= gap;
        n_merge++;
      end
    endfunction

    function void note_input(action_t act, time_t s, time_t e, logic [ADDR_W-1:0] idx);
      answer_t a;
      status_t st;
      a = '{lo: '0, hi: '0, rd_ok: 1'b0, count: '0, stat: STAT_OK};
      case (act)
        ACT_INSERT: begin
          n_insert++;
          if (s > e) begin
            a.stat = STAT_REVERSED;
            n_reversed++;
          end else begin
            place_window(s, e, st);
            a.stat = st;
          end
        end
        ACT_READ: begin
          if (idx < stored) begin
            a.lo    = win_lo[idx];
            a.hi    = win_hi[idx];
            a.rd_ok = 1'b1;
            n_read_hit++;
          end else begin
            n_read_miss++;
          end
        end
        ACT_CLEAR: begin
          stored = 0;
          n_clear++;
        end
        default: begin
        end
      endcase
      a.count = CNT_W'(stored);
      if (stored > peak) peak = stored;
      answers.insert(answers.size(), a);
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      if (errors < MAX_PRINTED)
        $display("ERROR %0t ns: %s got %0h expected %0h", $time, what, got, want);
      errors++;
    endtask

    task check_result(time_t lo, time_t hi, logic rd_ok, logic [CNT_W-1:0] cnt,
                      logic [STAT_W-1:0] st);
      answer_t a;
      if (answers.size() == 0) begin
        report_mismatch("result with nothing outstanding", {cnt, st}, '0);
        return;
      end
      a = answers.pop_front();
      if (lo !== a.lo)         report_mismatch("entry_start", lo, a.lo);
      if (hi !== a.hi)         report_mismatch("entry_stop", hi, a.hi);
      if (rd_ok !== a.rd_ok)   report_mismatch("read_valid", rd_ok, a.rd_ok);
      if (cnt !== a.count)     report_mismatch("entry_count", cnt, a.count);
      if (st !== a.stat)       report_mismatch("status", st, a.stat);
    endtask
  endclass

  logic                clk            = 1'b0;
  logic                rst_n          = 1'b0;
  logic                in_valid       = 1'b0;
  logic [ACT_W-1:0]    in_action      = ACT_NONE;
  time_t               in_win_start   = '0;
  time_t               in_win_stop    = '0;
  logic [ADDR_W-1:0]   in_entry_index = '0;
  logic                out_stall      = 1'b0;
  logic                in_stall;
  logic                out_valid;
  time_t               out_entry_start;
  time_t               out_entry_stop;
  logic                out_read_valid;
  logic [CNT_W-1:0]    out_entry_count;
  logic [STAT_W-1:0]   out_status;

  int unsigned         idle_pct  = 0;
  int unsigned         stall_pct = 0;
  int unsigned         quiet_cycles = 0;
  int                  issued = 0;
  coalesce_scoreboard  sb;

  always #2 clk = ~clk;

  interval_set_insert_coalesce u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_win_start    (in_win_start),
    .in_win_stop     (in_win_stop),
    .in_entry_index  (in_entry_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_entry_start (out_entry_start),
    .out_entry_stop  (out_entry_stop),
    .out_read_valid  (out_read_valid),
    .out_entry_count (out_entry_count),
    .out_status      (out_status)
  );

  // Stall the result side at random, check each result transfer, watch for a hang.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
    if (rst_n) begin
      if (out_valid && !out_stall)
        sb.check_result(out_entry_start, out_entry_stop, out_read_valid,
                        out_entry_count, out_status);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", quiet_cycles);
        $display("FAIL interval_set_insert_coalesce");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Drive one item, idling first at random, and hold it until the transfer.
  task automatic send_op(action_t act, time_t s, time_t e, logic [ADDR_W-1:0] idx);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_action      <= act;
    in_win_start   <= s;
    in_win_stop    <= e;
    in_entry_index <= idx;
    do @(posedge clk); while (in_stall);
    sb.note_input(act, s, e, idx);
    if (act != ACT_NONE) issued++;
  endtask

  // Hold off the sender until every outstanding result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.answers.size() != 0);
  endtask

  // One fill sequence on a coarse grid around a base time, closed by a clear.
  task automatic run_session();
    time_t             base;
    time_t             s;
    time_t             e;
    time_t             tmp;
    int                len;
    int                pick;
    logic [ADDR_W-1:0] idx;
    pick = $urandom_range(7);
    if (pick == 0)      base = T_MIN;
    else if (pick == 1) base = T_MAX - 2048;
    else                base = time_t'($urandom);
    len = $urandom_range(40, 90);
    repeat (len) begin
      pick = $urandom_range(99);
      idx  = ADDR_W'($urandom_range(31));
      if (pick < 8) begin
        // noise: any action, any bits
        s = time_t'($urandom);
        e = time_t'($urandom);
        send_op(action_t'($urandom_range(3)), s, e, idx);
      end else if (pick < 78) begin
        // widths near the grid step give touch, overlap and one-apart cases
        s = base + 8 * $urandom_range(127);
        e = s + (($urandom_range(9) == 0) ? $urandom_range(300) : $urandom_range(9));
        if ($urandom_range(19) == 0) begin
          tmp = s;
          s   = e + 1;
          e   = tmp;
        end
        send_op(ACT_INSERT, s, e, idx);
      end else begin
        send_op(ACT_READ, '0, '0, idx);
      end
    end
    send_op(ACT_CLEAR, '0, '0, '0);
  endtask

  initial begin
    sb = new;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table, reversed windows, touch and gap rules, extremes.
    send_op(ACT_READ,   '0, '0, '0);
    send_op(ACT_NONE,   7, 9, 5'd3);
    send_op(ACT_INSERT, 5, 4, '0);
    send_op(ACT_INSERT, 10, 20, '0);
    send_op(ACT_INSERT, 21, 30, '0);
    send_op(ACT_INSERT, 30, 40, '0);
    send_op(ACT_INSERT, T_MIN, T_MIN, '0);
    send_op(ACT_INSERT, T_MAX, T_MAX, '0);
    send_op(ACT_INSERT, -5, -5, '0);
    send_op(ACT_INSERT, 0, 25, '0);
    send_op(ACT_READ,   '0, '0, 5'd0);
    send_op(ACT_READ,   '0, '0, 5'd1);
    send_op(ACT_READ,   '0, '0, 5'd2);
    send_op(ACT_READ,   '0, '0, 5'd3);
    send_op(ACT_READ,   '0, '0, 5'd4);
    send_op(ACT_READ,   '0, '0, 5'd31);
    send_op(ACT_INSERT, T_MIN, T_MAX, '0);
    send_op(ACT_READ,   '0, '0, 5'd0);
    send_op(ACT_INSERT, T_MAX, T_MIN, '0);
    send_op(ACT_CLEAR,  '0, '0, '0);
    send_op(ACT_READ,   '0, '0, 5'd0);
    send_op(ACT_INSERT, -1, 0, '0);
    send_op(ACT_NONE,   '0, '0, '0);

    // Random fill sequences under each idling mix, draining between mixes.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 59;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 59;
        end
        default: begin
          idle_pct  = 12;
          stall_pct = 12;
        end
      endcase
      while (issued < (ph + 1) * PHASE_ITEMS) run_session();
      drain_results();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Covered %0d inserts (%0d merged, %0d dropped on a full table, %0d reversed),",
             sb.n_insert, sb.n_merge, sb.n_full, sb.n_reversed);
    $display("%0d reads (%0d in range), %0d clears; peak window count %0d; %0d mismatches.",
             sb.n_read_hit + sb.n_read_miss, sb.n_read_hit, sb.n_clear, sb.peak, sb.errors);
    if (sb.errors == 0 && sb.answers.size() == 0) begin
      $display("PASS interval_set_insert_coalesce");
    end else begin
      $display("FAIL interval_set_insert_coalesce");
    end
    $finish;
  end

endmodule
